[hdl/vic_pkg.sv]
// ----------------------------------------------------------------------------
// vic_pkg
// Shared types and constants of the vectored interrupt controller.
// ----------------------------------------------------------------------------
package vic_pkg;

  localparam int SOURCES_DEF     = 64;
  localparam int VECTOR_BITS_DEF = 8;
  localparam int MAX_SOURCES     = 64;
  localparam int BANK_BITS       = 32;
  localparam int SRC_NUM_BITS    = 6;
  localparam int VEC_FIELD_BITS  = 8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_TABLE = 2'd3
  } vic_op_t;

  localparam logic [3:0] IDX_PENDING_HI = 4'd4;
  localparam logic [3:0] IDX_PENDING_LO = 4'd8;
  localparam logic [3:0] IDX_MASK_HI    = 4'd5;
  localparam logic [3:0] IDX_MASK_LO    = 4'd9;
  localparam logic [3:0] IDX_ACK_HI     = 4'd6;
  localparam logic [3:0] IDX_ACK_LO     = 4'd10;

  localparam logic [1:0] CFG_ADDR_DEFAULT_VECTOR = 2'd0;

  typedef struct packed {
    logic                 none;
    logic [BANK_BITS-1:0] rdata;
  } vic_stat_t;

endpackage

[hdl/vic_ram.sv]
// ----------------------------------------------------------------------------
// vic_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module vic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/vic_bank.sv]
// ----------------------------------------------------------------------------
// vic_bank
// Pending and mask registers, bank register access and priority encode.
// ----------------------------------------------------------------------------
module vic_bank #(
  parameter int SOURCES = vic_pkg::SOURCES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  vic_pkg::vic_op_t                  op,
  input  logic [vic_pkg::MAX_SOURCES-1:0]   lines,
  input  logic [3:0]                        idx,
  input  logic [vic_pkg::BANK_BITS-1:0]     data,
  output logic [$clog2(SOURCES)-1:0]        found,
  output vic_pkg::vic_stat_t                stat
);

  localparam int SRC_W = $clog2(SOURCES);
  localparam int BB    = vic_pkg::BANK_BITS;

  logic [SOURCES-1:0]              pending_r, pending_nxt;
  logic [SOURCES-1:0]              mask_r, mask_nxt;
  logic [vic_pkg::MAX_SOURCES-1:0] pend_s, mask_w, ack_w;
  logic [BB-1:0]                   rdata;

  always_comb begin
    pend_s = vic_pkg::MAX_SOURCES'(pending_r | (lines[SOURCES-1:0] & mask_r));
    mask_w = vic_pkg::MAX_SOURCES'(mask_r);
    ack_w  = '0;
    rdata  = '0;
    if (op == vic_pkg::OP_READ) begin
      case (idx)
        vic_pkg::IDX_PENDING_HI: rdata = pend_s[2*BB-1:BB];
        vic_pkg::IDX_PENDING_LO: rdata = pend_s[BB-1:0];
        vic_pkg::IDX_MASK_HI:    rdata = mask_w[2*BB-1:BB];
        vic_pkg::IDX_MASK_LO:    rdata = mask_w[BB-1:0];
        default:                 rdata = '0;
      endcase
    end else if (op == vic_pkg::OP_WRITE) begin
      case (idx)
        vic_pkg::IDX_MASK_HI: mask_w = {data, mask_w[BB-1:0]};
        vic_pkg::IDX_MASK_LO: mask_w = {mask_w[2*BB-1:BB], data};
        vic_pkg::IDX_ACK_HI:  ack_w  = {data, {BB{1'b0}}};
        vic_pkg::IDX_ACK_LO:  ack_w  = {{BB{1'b0}}, data};
        default:              ack_w  = '0;
      endcase
    end
    pending_nxt = pend_s[SOURCES-1:0] & ~ack_w[SOURCES-1:0];
    mask_nxt    = mask_w[SOURCES-1:0];
  end

  // lowest-numbered pending source
  always_comb begin
    found = '0;
    for (int i = SOURCES - 1; i >= 0; i--) begin
      if (pending_nxt[i]) begin
        found = SRC_W'(i);
      end
    end
    stat.none  = ~|pending_nxt;
    stat.rdata = rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      mask_r    <= '0;
    end else if (step) begin
      pending_r <= pending_nxt;
      mask_r    <= mask_nxt;
    end
  end

endmodule

[hdl/vic_vtab.sv]
// ----------------------------------------------------------------------------
// vic_vtab
// Source-to-vector table: RAM, per-entry valid bits, write forwarding.
// ----------------------------------------------------------------------------
module vic_vtab #(
  parameter int SOURCES     = vic_pkg::SOURCES_DEF,
  parameter int VECTOR_BITS = vic_pkg::VECTOR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [$clog2(SOURCES)-1:0] rd_addr,
  input  logic                       wr_en,
  input  logic [$clog2(SOURCES)-1:0] wr_addr,
  input  logic [VECTOR_BITS-1:0]     wr_data,
  output logic [VECTOR_BITS-1:0]     entry
);

  logic [SOURCES-1:0]     valid_r;
  logic                   hit_valid_r;
  logic                   fwd_r;
  logic [VECTOR_BITS-1:0] fwd_vec_r;
  logic [VECTOR_BITS-1:0] ram_q;

  vic_ram #(
    .WIDTH(VECTOR_BITS),
    .DEPTH(SOURCES)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      hit_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_valid_r <= valid_r[rd_addr];
        fwd_r       <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_vec_r <= wr_data;
    end
  end

  // write in the same transfer as the lookup wins over the stored entry
  assign entry = fwd_r ? fwd_vec_r : (hit_valid_r ? ram_q : '0);

endmodule

[hdl/vectored_interrupt_controller_core.sv]
// ----------------------------------------------------------------------------
// vectored_interrupt_controller_core
// 64-source priority interrupt controller with vector table and APB config.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------
//   in_      | in_valid/in_ready  | operation, irq_lines, reg_index, ...
//   out_     | out_valid/out_ready| read_data, none_pending, source, vector
//   config   | psel/penable/...   | default_vector at address 0
//
// One transfer per cycle in and out while out_ready is held high; a result is offered
// after its input transfer passes the input register, table read and output register.
// The vector table RAM read port sets the middle stage.
// rst_n is synchronous; the table reads as zero after reset via valid bits.
// While a result waits, two more input transfers fill the stages behind it,
// then in_ready follows out_ready.
// ----------------------------------------------------------------------------
module vectored_interrupt_controller_core #(
  parameter int SOURCES     = vic_pkg::SOURCES_DEF,
  parameter int VECTOR_BITS = vic_pkg::VECTOR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_irq_lines,
  input  logic [3:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  input  logic [5:0]  in_source_number,
  input  logic [7:0]  in_vector_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_none_pending,
  output logic [5:0]  out_pending_source,
  output logic [7:0]  out_current_vector,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SRC_W = $clog2(SOURCES);

  // input stage
  logic                  s1_valid_r;
  vic_pkg::vic_op_t      s1_op_r;
  logic [63:0]           s1_lines_r;
  logic [3:0]            s1_idx_r;
  logic [31:0]           s1_data_r;
  logic [5:0]            s1_src_r;
  logic [7:0]            s1_vec_r;

  // lookup stage
  logic                  s2_valid_r;
  vic_pkg::vic_stat_t    s2_stat_r;
  logic [SRC_W-1:0]      s2_found_r;

  // output stage
  logic                  out_valid_r;

  logic [VECTOR_BITS-1:0] def_vec_r;

  logic                   adv_o, rdy2, adv1, adv2;
  logic [SRC_W-1:0]       found;
  vic_pkg::vic_stat_t     stat;
  logic                   tab_we;
  logic [VECTOR_BITS-1:0] entry, cur_vec;

  assign adv_o    = !out_valid_r || out_ready;
  assign rdy2     = !s2_valid_r || adv_o;
  assign adv1     = s1_valid_r && rdy2;
  assign adv2     = s2_valid_r && adv_o;
  assign in_ready = !s1_valid_r || rdy2;

  assign tab_we = adv1 && (s1_op_r == vic_pkg::OP_TABLE) &&
                  ({1'b0, s1_src_r} < 7'(SOURCES));

  vic_bank #(
    .SOURCES(SOURCES)
  ) u_bank (
    .clk  (clk),
    .rst_n(rst_n),
    .step (adv1),
    .op   (s1_op_r),
    .lines(s1_lines_r),
    .idx  (s1_idx_r),
    .data (s1_data_r),
    .found(found),
    .stat (stat)
  );

  vic_vtab #(
    .SOURCES    (SOURCES),
    .VECTOR_BITS(VECTOR_BITS)
  ) u_vtab (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (adv1),
    .rd_addr(found),
    .wr_en  (tab_we),
    .wr_addr(s1_src_r[SRC_W-1:0]),
    .wr_data(VECTOR_BITS'(s1_vec_r)),
    .entry  (entry)
  );

  assign cur_vec = (s2_stat_r.none || entry == '0) ? def_vec_r : entry;

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (rdy2) begin
        s2_valid_r <= adv1;
      end
      if (adv_o) begin
        out_valid_r <= adv2;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r    <= vic_pkg::vic_op_t'(in_operation);
      s1_lines_r <= in_irq_lines;
      s1_idx_r   <= in_reg_index;
      s1_data_r  <= in_write_data;
      s1_src_r   <= in_source_number;
      s1_vec_r   <= in_vector_value;
    end
    if (adv1) begin
      s2_stat_r  <= stat;
      s2_found_r <= found;
    end
    if (adv2) begin
      out_read_data      <= s2_stat_r.rdata;
      out_none_pending   <= s2_stat_r.none;
      out_pending_source <= 6'(s2_found_r);
      out_current_vector <= 8'(cur_vec);
    end
  end

  assign out_valid = out_valid_r;

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_vec_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == vic_pkg::CFG_ADDR_DEFAULT_VECTOR) begin
      def_vec_r <= VECTOR_BITS'(pwdata[7:0]);
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == vic_pkg::CFG_ADDR_DEFAULT_VECTOR) ? 32'(def_vec_r) : 32'd0;

endmodule

[tb/vectored_interrupt_controller_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vectored_interrupt_controller_core_tb
// Drives sampled irq lines, bank register accesses and vector table writes
// into the controller under random gaps on both channels. An in-house model
// of the pending, mask and table state predicts read data and the
// lowest-numbered pending source with its vector for every transfer. The
// default vector is reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module vectored_interrupt_controller_core_tb;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SQUEEZE_AT     = 700;
  localparam int          SQUEEZE_CYCLES = 300;
  localparam int          PHASE_ITEMS    = 325;
  localparam logic [3:0]  IDX_UNUSED     = 4'd15;
  localparam logic [63:0] ALL_LINES      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] ALL_WORD       = 32'hFFFF_FFFF;

  typedef struct {
    vic_pkg::vic_op_t op;
    logic [63:0]      lines;
    logic [3:0]       reg_index;
    logic [31:0]      wdata;
    logic [5:0]       src;
    logic [7:0]       vec;
  } irq_item_t;

  typedef struct {
    logic [31:0] read_data;
    logic        none_pending;
    logic [5:0]  pending_source;
    logic [7:0]  current_vector;
  } status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = vic_pkg::OP_TICK;
  logic [63:0] in_irq_lines = '0;
  logic [3:0]  in_reg_index = '0;
  logic [31:0] in_write_data = '0;
  logic [5:0]  in_source_number = '0;
  logic [7:0]  in_vector_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_read_data;
  logic        out_none_pending;
  logic [5:0]  out_pending_source;
  logic [7:0]  out_current_vector;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // controller state as predicted
  logic [63:0] pend_bits = '0;
  logic [63:0] enable_bits = '0;
  logic [7:0]  vec_table [vic_pkg::MAX_SOURCES] = '{default: 8'h00};
  logic [7:0]  dflt_vector = '0;

  irq_item_t   irq_item_q[$];
  status_t     status_q[$];
  irq_item_t   cur_item;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int          in_gap_max = 2;
  int          out_gap_max = 2;
  int          in_wait = 0;
  int          out_wait = 0;
  int          squeeze_left = 0;
  bit          squeeze_done = 1'b0;
  int          in_accepted = 0;
  int          errors = 0;
  int          stall_cycles = 0;

  vectored_interrupt_controller_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_irq_lines       (in_irq_lines),
    .in_reg_index       (in_reg_index),
    .in_write_data      (in_write_data),
    .in_source_number   (in_source_number),
    .in_vector_value    (in_vector_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_none_pending   (out_none_pending),
    .out_pending_source (out_pending_source),
    .out_current_vector (out_current_vector),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sample lines, apply the operation, then priority-encode
  function automatic status_t advance_controller(irq_item_t it);
    status_t s;
    s.read_data      = '0;
    s.none_pending   = 1'b1;
    s.pending_source = '0;
    pend_bits = pend_bits | (it.lines & enable_bits);
    case (it.op)
      vic_pkg::OP_READ: begin
        case (it.reg_index)
          vic_pkg::IDX_PENDING_HI: s.read_data = pend_bits[63:32];
          vic_pkg::IDX_PENDING_LO: s.read_data = pend_bits[31:0];
          vic_pkg::IDX_MASK_HI:    s.read_data = enable_bits[63:32];
          vic_pkg::IDX_MASK_LO:    s.read_data = enable_bits[31:0];
          default:                 s.read_data = '0;
        endcase
      end
      vic_pkg::OP_WRITE: begin
        case (it.reg_index)
          vic_pkg::IDX_MASK_HI: enable_bits[63:32] = it.wdata;
          vic_pkg::IDX_MASK_LO: enable_bits[31:0] = it.wdata;
          vic_pkg::IDX_ACK_HI:  pend_bits[63:32] = pend_bits[63:32] & ~it.wdata;
          vic_pkg::IDX_ACK_LO:  pend_bits[31:0] = pend_bits[31:0] & ~it.wdata;
          default: ;
        endcase
      end
      vic_pkg::OP_TABLE: vec_table[it.src] = it.vec;
      default: ;
    endcase
    for (int i = vic_pkg::MAX_SOURCES - 1; i >= 0; i--) begin
      if (pend_bits[i]) begin
        s.pending_source = 6'(i);
        s.none_pending   = 1'b0;
      end
    end
    if (s.none_pending || vec_table[s.pending_source] == 8'h00) begin
      s.current_vector = dflt_vector;
    end else begin
      s.current_vector = vec_table[s.pending_source];
    end
    return s;
  endfunction

  function automatic irq_item_t irq_item(vic_pkg::vic_op_t op, logic [63:0] lines,
                                         logic [3:0] idx, logic [31:0] wdata,
                                         logic [5:0] src, logic [7:0] vec);
    irq_item_t it;
    it.op        = op;
    it.lines     = lines;
    it.reg_index = idx;
    it.wdata     = wdata;
    it.src       = src;
    it.vec       = vec;
    return it;
  endfunction

  function automatic irq_item_t random_irq_item();
    irq_item_t   it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.op = vic_pkg::OP_TICK;
    end else if (pick < 55) begin
      it.op = vic_pkg::OP_READ;
    end else if (pick < 80) begin
      it.op = vic_pkg::OP_WRITE;
    end else begin
      it.op = vic_pkg::OP_TABLE;
    end
    // mostly sparse lines so the pending set keeps changing
    case ($urandom_range(0, 7))
      0:       it.lines = '0;
      1:       it.lines = ALL_LINES;
      2:       it.lines = {$urandom, $urandom};
      3:       it.lines = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
      default: it.lines = 64'd1 << $urandom_range(0, 63);
    endcase
    if ($urandom_range(0, 9) == 0) begin
      it.reg_index = 4'($urandom_range(0, 15));
    end else begin
      case ($urandom_range(0, 5))
        0:       it.reg_index = vic_pkg::IDX_PENDING_HI;
        1:       it.reg_index = vic_pkg::IDX_PENDING_LO;
        2:       it.reg_index = vic_pkg::IDX_MASK_HI;
        3:       it.reg_index = vic_pkg::IDX_MASK_LO;
        4:       it.reg_index = vic_pkg::IDX_ACK_HI;
        default: it.reg_index = vic_pkg::IDX_ACK_LO;
      endcase
    end
    case ($urandom_range(0, 3))
      0:       it.wdata = $urandom;
      1:       it.wdata = ALL_WORD;
      2:       it.wdata = 32'd1 << $urandom_range(0, 31);
      default: it.wdata = $urandom & $urandom;
    endcase
    it.src = 6'($urandom_range(0, 63));
    it.vec = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic set_default_vector(input logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= vic_pkg::CFG_ADDR_DEFAULT_VECTOR;
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    dflt_vector = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    while (irq_item_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (in_wait > 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (irq_item_q.size() != 0) begin
        cur_item = irq_item_q.pop_front();
        in_operation     <= cur_item.op;
        in_irq_lines     <= cur_item.lines;
        in_reg_index     <= cur_item.reg_index;
        in_write_data    <= cur_item.wdata;
        in_source_number <= cur_item.src;
        in_vector_value  <= cur_item.vec;
        in_valid         <= 1'b1;
        in_wait = $urandom_range(0, in_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!squeeze_done && in_accepted >= SQUEEZE_AT) begin
        squeeze_left = SQUEEZE_CYCLES;
        squeeze_done = 1'b1;
      end
      if (out_fire) out_wait = $urandom_range(0, out_gap_max);
      if (squeeze_left > 0) begin
        squeeze_left--;
        out_ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // transfer monitor and checker
  always @(posedge clk) begin : monitor
    status_t want;
    if (!rst_n) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && in_ready;
      out_fire <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        status_q.push_back(advance_controller(cur_item));
        in_accepted++;
      end
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $error("result transfer with nothing outstanding");
          errors++;
        end else begin
          want = status_q.pop_front();
          if (out_read_data !== want.read_data) begin
            $error("read_data expected %h got %h", want.read_data, out_read_data);
            errors++;
          end
          if (out_none_pending !== want.none_pending) begin
            $error("none_pending expected %0d got %0d", want.none_pending, out_none_pending);
            errors++;
          end
          if (out_pending_source !== want.pending_source) begin
            $error("pending_source expected %0d got %0d", want.pending_source,
                   out_pending_source);
            errors++;
          end
          if (out_current_vector !== want.current_vector) begin
            $error("current_vector expected %h got %h", want.current_vector,
                   out_current_vector);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] dv;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    irq_item_q.push_back(irq_item(vic_pkg::OP_TICK, ALL_LINES, vic_pkg::IDX_PENDING_LO,
                                  '0, '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_READ, '0, vic_pkg::IDX_MASK_LO, '0, '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_WRITE, '0, vic_pkg::IDX_MASK_LO, ALL_WORD,
                                  '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_WRITE, '0, vic_pkg::IDX_MASK_HI, ALL_WORD,
                                  '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_READ, '0, vic_pkg::IDX_MASK_HI, '0, '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_TICK, 64'h8000_0000_0000_0000,
                                  vic_pkg::IDX_MASK_HI, '0, '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_TABLE, '0, '0, '0, 6'd63, 8'hFF));
    irq_item_q.push_back(irq_item(vic_pkg::OP_TABLE, '0, '0, '0, 6'd0, 8'h01));
    irq_item_q.push_back(irq_item(vic_pkg::OP_TICK, 64'd1, '0, '0, '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_READ, '0, vic_pkg::IDX_PENDING_HI,
                                  '0, '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_READ, '0, vic_pkg::IDX_PENDING_LO,
                                  '0, '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_WRITE, '0, vic_pkg::IDX_ACK_LO, 32'd1,
                                  '0, '0));
    // write-only and unknown indexes read back as zero
    irq_item_q.push_back(irq_item(vic_pkg::OP_READ, '0, vic_pkg::IDX_ACK_HI, '0, '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_READ, '0, IDX_UNUSED, '0, '0, '0));
    // writes to pending and unknown indexes are dropped
    irq_item_q.push_back(irq_item(vic_pkg::OP_WRITE, '0, vic_pkg::IDX_PENDING_HI, ALL_WORD,
                                  '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_WRITE, '0, IDX_UNUSED, ALL_WORD, '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_WRITE, '0, vic_pkg::IDX_ACK_HI, ALL_WORD,
                                  '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_TICK, ALL_LINES, '0, '0, '0, '0));
    // unmapped source falls back to the default vector
    irq_item_q.push_back(irq_item(vic_pkg::OP_WRITE, '0, vic_pkg::IDX_ACK_LO, ALL_WORD,
                                  '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_TABLE, '0, '0, '0, 6'd32, 8'h5A));
    irq_item_q.push_back(irq_item(vic_pkg::OP_TABLE, '0, '0, '0, 6'd32, 8'h00));
    irq_item_q.push_back(irq_item(vic_pkg::OP_WRITE, '0, vic_pkg::IDX_ACK_HI, ALL_WORD,
                                  '0, '0));
    // lines are sampled before the mask write in the same transfer
    irq_item_q.push_back(irq_item(vic_pkg::OP_WRITE, ALL_LINES, vic_pkg::IDX_MASK_LO,
                                  '0, '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_WRITE, '0, vic_pkg::IDX_MASK_HI, '0, '0, '0));
    irq_item_q.push_back(irq_item(vic_pkg::OP_WRITE, ALL_LINES, vic_pkg::IDX_ACK_LO,
                                  ALL_WORD, '0, '0));

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0:       dv = 8'hFF;
        1:       dv = 8'h00;
        2:       dv = 8'($urandom_range(1, 254));
        3:       dv = 8'h01;
        4:       dv = 8'h80;
        default: dv = 8'($urandom_range(0, 255));
      endcase
      set_default_vector(dv);
      @(posedge clk);
      case (p)
        0:       begin in_gap_max = 18; out_gap_max = 18; end
        1:       begin in_gap_max = 0;  out_gap_max = 0;  end
        2:       begin in_gap_max = 0;  out_gap_max = 18; end
        3:       begin in_gap_max = 18; out_gap_max = 0;  end
        4:       begin in_gap_max = 3;  out_gap_max = 3;  end
        default: begin in_gap_max = 18; out_gap_max = 18; end
      endcase
      repeat (PHASE_ITEMS) irq_item_q.push_back(random_irq_item());
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
hdl/vic_pkg.sv
hdl/vic_ram.sv
hdl/vic_bank.sv
hdl/vic_vtab.sv
hdl/vectored_interrupt_controller_core.sv
tb/vectored_interrupt_controller_core_tb.sv
